>>> rtl/core/chn_pkg.sv
// Shared types and constants for the character histogram normalizer.
// No dependencies; imported by the top level, chn_front and chn_back.
`default_nettype none
package chn_pkg;

   localparam int MAP_ENTRIES = 256;
   localparam int SUM_W       = 38;
   localparam int COUNT_W     = 16;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_TEXT = 2'd1,
      OP_EMIT = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REG_VOCAB_SIZE = 2'd0,
      REG_UNK_ENABLE = 2'd1,
      REG_UNK_BIN    = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TXT_MAP,
      ST_TXT_CNT,
      ST_SUM_RD,
      ST_SUM_MUL,
      ST_SUM_ACC,
      ST_EM_RD,
      ST_EM_MUL,
      ST_DIV,
      ST_SQRT,
      ST_OUT
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] byte_value;
      logic [6:0] table_bin;
   } item_type;

   typedef struct packed {
      logic [6:0] vocab_size;
      logic       unknown_enable;
      logic [5:0] unknown_bin;
   } cfg_type;

   typedef struct packed {
      state_type  st;
      logic       sum_zero;
      logic [6:0] n_eff;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/core/char_histogram_l2_normalizer.sv
// Top level of the character histogram normalizer: registers, front, back.
// Depends on chn_pkg, chn_front, chn_back.
//
//  channel  prefix  dir  handshake        payload
//  request  req_    in   valid/ready      operation, byte_value, table_bin
//  result   rsp_    out  valid/ready      bin_number, norm_value, last_of_run
//  config   csr_    in   valid/ready      index, wdata
//
// Load: written to the map RAM by the back end; text byte: map RAM read, then count RAM update.
// End of text: per bin a read, square and add for the sum, then per bin a read and square,
// 64 divider steps and 16 square-root steps, plus output waits.
// Synchronous reset; map and count entries read as their reset values until written.
// A two-item queue lets requests enter while the back end works or the result stalls.
`default_nettype none
module char_histogram_l2_normalizer #(
   parameter int MAX_BINS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [1:0]        req_operation,
   input  wire logic [7:0]        req_byte_value,
   input  wire logic signed [6:0] req_table_bin,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [5:0]        rsp_bin_number,
   output      logic [15:0]       rsp_norm_value,
   output      logic              rsp_last_of_run,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [6:0]        csr_wdata
);
   import chn_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       q_valid, q_pop;
   item_type   q_item;
   status_type stat;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_VOCAB_SIZE: cfg_in.vocab_size     = csr_wdata;
            REG_UNK_ENABLE: cfg_in.unknown_enable = csr_wdata[0];
            REG_UNK_BIN:    cfg_in.unknown_bin    = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{vocab_size: 7'd64, unknown_enable: 1'b0, unknown_bin: 6'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   chn_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_operation(req_operation),
      .req_byte_value(req_byte_value), .req_table_bin(req_table_bin),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop));

   chn_back #(.MAX_BINS(MAX_BINS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .cfg(cfg_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_bin_number(rsp_bin_number),
      .rsp_norm_value(rsp_norm_value), .rsp_last_of_run(rsp_last_of_run),
      .stat(stat));

`ifndef SYNTHESIS
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      stat.st == ST_DIV |-> !stat.sum_zero)
      else $error("divider running with zero sum");
   a_last_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |-> rsp_bin_number == 6'(stat.n_eff - 7'd1))
      else $error("last item not on final bin");
   a_sqrt_after_div: assert property (@(posedge clock) disable iff (reset)
      stat.st == ST_SQRT && $past(stat.st) != ST_SQRT |-> $past(stat.st) == ST_DIV)
      else $error("square root entered without division");
`endif
endmodule
`default_nettype wire

>>> rtl/core/chn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module chn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/core/chn_front.sv
// Front end: accepts request items, decodes the operation, queues those with a known operation.
// Depends on chn_pkg.
`default_nettype none
module chn_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [1:0]        req_operation,
   input  wire logic [7:0]        req_byte_value,
   input  wire logic signed [6:0] req_table_bin,
   output      logic              q_valid,
   output      chn_pkg::item_type q_item,
   input  wire logic              q_pop
);
   import chn_pkg::*;

   item_type   ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       known;
   item_type   new_item;

   always_comb begin
      unique case (req_operation)
         OP_LOAD, OP_TEXT, OP_EMIT: known = 1'b1;
         default:                   known = 1'b0;
      endcase
   end

   assign new_item  = '{op: op_type'(req_operation), byte_value: req_byte_value,
                        table_bin: req_table_bin};
   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready && known;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (q_pop && q_valid) ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_item;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/chn_back.sv
// Back end: byte map, bin counts, sum of squares, divider and square root.
// Depends on chn_pkg and chn_ram.
`default_nettype none
module chn_back #(
   parameter int MAX_BINS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire chn_pkg::item_type   q_item,
   output      logic                q_pop,
   input  wire chn_pkg::cfg_type    cfg,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [5:0]          rsp_bin_number,
   output      logic [15:0]         rsp_norm_value,
   output      logic                rsp_last_of_run,
   output      chn_pkg::status_type stat
);
   import chn_pkg::*;

   localparam int BIN_W = $clog2(MAX_BINS);
   localparam int CNT_W = $clog2(MAX_BINS + 1);

   state_type             st_ff, st_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [5:0]            step_ff, step_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [31:0]           sq_ff, sq_in;
   logic [63:0]           dvd_ff, dvd_in;
   logic [SUM_W-1:0]      rem_ff, rem_in;
   logic [15:0]           root_ff, root_in;
   logic [17:0]           srem_ff, srem_in;
   logic [15:0]           res_ff, res_in;
   logic [BIN_W-1:0]      addr_ff, addr_in;
   logic [7:0]            map_addr_ff, map_addr_in;
   logic [MAX_BINS-1:0]   cnt_vld_ff, cnt_vld_in;
   logic [MAP_ENTRIES-1:0] map_vld_ff, map_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [5:0]            rsp_bin_ff, rsp_bin_in;
   logic [15:0]           rsp_norm_ff, rsp_norm_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]      n_eff;
   logic [6:0]            map_rdata, map_e;
   logic [COUNT_W-1:0]    cnt_rdata, cnt_c;
   logic                  map_we, cnt_we;
   logic [COUNT_W-1:0]    cnt_wdata;
   logic [BIN_W-1:0]      cnt_raddr;
   logic                  hit;
   logic [BIN_W-1:0]      target;
   logic [SUM_W:0]        rem_sh;
   logic                  div_ge;
   logic [19:0]           srem_sh, trial;
   logic                  sq_ge;
   logic                  out_free, last_k;

   chn_ram #(.WIDTH(7), .DEPTH(MAP_ENTRIES)) u_map (
      .clock(clock), .wr_en(map_we), .wr_addr(q_item.byte_value),
      .wr_data(q_item.table_bin), .rd_addr(q_item.byte_value), .rd_data(map_rdata));

   chn_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_BINS)) u_cnt (
      .clock(clock), .wr_en(cnt_we), .wr_addr(addr_ff), .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr), .rd_data(cnt_rdata));

   always_comb begin
      if (cfg.vocab_size == 7'd0) begin
         n_eff = CNT_W'(1);
      end else if (cfg.vocab_size > 7'(MAX_BINS)) begin
         n_eff = CNT_W'(MAX_BINS);
      end else begin
         n_eff = CNT_W'(cfg.vocab_size);
      end
   end

   assign map_e  = map_vld_ff[map_addr_ff] ? map_rdata : 7'h7F;
   assign cnt_c  = cnt_vld_ff[addr_ff] ? cnt_rdata : '0;
   assign last_k = (k_ff + CNT_W'(1)) == n_eff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (!map_e[6]) begin
         hit    = 7'(map_e[5:0]) < 7'(n_eff);
         target = BIN_W'(map_e[5:0]);
      end else begin
         hit    = cfg.unknown_enable && (7'(cfg.unknown_bin) < 7'(n_eff));
         target = BIN_W'(cfg.unknown_bin);
      end
   end

   assign rem_sh  = {rem_ff, dvd_ff[63]};
   assign div_ge  = rem_sh >= {1'b0, sum_ff};
   assign srem_sh = {srem_ff, dvd_ff[31:30]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign sq_ge   = srem_sh >= trial;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_item.op)
                  OP_TEXT: st_in = ST_TXT_MAP;
                  OP_EMIT: st_in = ST_SUM_RD;
                  default: st_in = ST_IDLE;
               endcase
            end
         end
         ST_TXT_MAP: st_in = hit ? ST_TXT_CNT : ST_IDLE;
         ST_TXT_CNT: st_in = ST_IDLE;
         ST_SUM_RD:  st_in = ST_SUM_MUL;
         ST_SUM_MUL: st_in = ST_SUM_ACC;
         ST_SUM_ACC: st_in = last_k ? ST_EM_RD : ST_SUM_RD;
         ST_EM_RD:   st_in = ST_EM_MUL;
         ST_EM_MUL:  st_in = (sum_ff == '0) ? ST_OUT : ST_DIV;
         ST_DIV: begin
            if (step_ff == 6'd63) begin
               st_in = dvd_in[32] ? ST_OUT : ST_SQRT;
            end
         end
         ST_SQRT:    st_in = (step_ff[3:0] == 4'd15) ? ST_OUT : ST_SQRT;
         ST_OUT: begin
            if (out_free) begin
               st_in = last_k ? ST_IDLE : ST_EM_RD;
            end
         end
         default:    st_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      k_in         = k_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      res_in       = res_ff;
      addr_in      = addr_ff;
      map_addr_in  = map_addr_ff;
      cnt_vld_in   = cnt_vld_ff;
      map_vld_in   = map_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_bin_in   = rsp_bin_ff;
      rsp_norm_in  = rsp_norm_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      map_we       = 1'b0;
      cnt_we       = 1'b0;
      cnt_wdata    = (cnt_c == 16'hFFFF) ? cnt_c : cnt_c + 16'd1;
      cnt_raddr    = addr_ff;
      unique case (st_ff)
         ST_IDLE: begin
            q_pop       = q_valid;
            map_addr_in = q_item.byte_value;
            k_in        = '0;
            sum_in      = '0;
            addr_in     = '0;
            if (q_valid && q_item.op == OP_LOAD) begin
               map_we                          = 1'b1;
               map_vld_in[q_item.byte_value]   = 1'b1;
            end
         end
         ST_TXT_MAP: begin
            addr_in   = target;
            cnt_raddr = target;
         end
         ST_TXT_CNT: begin
            cnt_we           = 1'b1;
            cnt_vld_in[addr_ff] = 1'b1;
         end
         ST_SUM_RD, ST_EM_RD: begin
            addr_in   = BIN_W'(k_ff);
            cnt_raddr = BIN_W'(k_ff);
         end
         ST_SUM_MUL: sq_in = cnt_c * cnt_c;
         ST_SUM_ACC: begin
            sum_in = sum_ff + SUM_W'(sq_ff);
            k_in   = last_k ? '0 : k_ff + CNT_W'(1);
         end
         ST_EM_MUL: begin
            dvd_in  = {32'(cnt_c) * 32'(cnt_c), 32'd0};
            rem_in  = '0;
            step_in = '0;
            res_in  = '0;
         end
         ST_DIV: begin
            rem_in  = div_ge ? SUM_W'(rem_sh - {1'b0, sum_ff}) : SUM_W'(rem_sh);
            dvd_in  = {dvd_ff[62:0], div_ge};
            step_in = step_ff + 6'd1;
            srem_in = '0;
            root_in = '0;
            if (step_ff == 6'd63) begin
               step_in = '0;
               res_in  = 16'hFFFF;
            end
         end
         ST_SQRT: begin
            srem_in = sq_ge ? 18'(srem_sh - trial) : 18'(srem_sh);
            root_in = {root_ff[14:0], sq_ge};
            dvd_in  = {dvd_ff[61:0], 2'b00};
            step_in = step_ff + 6'd1;
            res_in  = root_in;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bin_in   = 6'(k_ff);
               rsp_norm_in  = res_ff;
               rsp_last_in  = last_k;
               k_in         = k_ff + CNT_W'(1);
               if (last_k) begin
                  cnt_vld_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         cnt_vld_ff   <= '0;
         map_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_vld_ff   <= cnt_vld_in;
         map_vld_ff   <= map_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      step_ff     <= step_in;
      sum_ff      <= sum_in;
      sq_ff       <= sq_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      res_ff      <= res_in;
      addr_ff     <= addr_in;
      map_addr_ff <= map_addr_in;
      rsp_bin_ff  <= rsp_bin_in;
      rsp_norm_ff <= rsp_norm_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bin_number  = rsp_bin_ff;
   assign rsp_norm_value  = rsp_norm_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign stat = '{st: st_ff, sum_zero: (sum_ff == '0), n_eff: 7'(n_eff)};
endmodule
`default_nettype wire
